// ===== hdl/vnf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vnf_pkg: shared constants and helpers for value noise fbm
// Hash constants, lattice strides and the corner hash helpers.
// ----------------------------------------------------------------------------
package vnf_pkg;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned OUT_W   = 18;
	localparam int unsigned FRAC_W  = 16;
	localparam logic [31:0] HASH_C1 = 32'd15731;
	localparam logic [31:0] HASH_C2 = 32'd789221;
	localparam logic [31:0] HASH_C3 = 32'd1376312589;
	localparam logic [31:0] HASH_MASK = 32'h7fffffff;
	localparam logic [31:0] STRIDE_Y = 32'd57;
	localparam logic [31:0] STRIDE_Z = 32'd113;
	localparam int unsigned HASH_SHL = 13;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Offset of corner c (bit0 x, bit1 y, bit2 z) from the base index.
	function automatic logic [31:0] corner_ofs(input logic [2:0] c);
		logic [31:0] r;
		r = {31'd0, c[0]};
		if (c[1]) r = r + STRIDE_Y;
		if (c[2]) r = r + STRIDE_Z;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/vnf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vnf_in_if / vnf_out_if: request channels of the noise unit
// Valid/ready channels carrying a point or a noise sample.
// ----------------------------------------------------------------------------
interface vnf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	modport source (output valid, output coord_x, output coord_y, output coord_z,
		input ready);
	modport sink (input valid, input coord_x, input coord_y, input coord_z,
		output ready);
endinterface

interface vnf_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] noise_value;
	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/value_noise_fbm_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// value_noise_fbm_unit: fractal value noise on a 3-D point
// Top level: seed register, octave pipelines, octave sum and output stage.
// ----------------------------------------------------------------------------
// Usage:
// Points arrive on pt (coord_x/y/z, signed fixed point) and noise samples
// leave on ns (noise_value, signed Q1.16), both valid/ready channels.
// The user must write the seed through seed_we/seed_wd while the unit is idle;
// the block itself does not enforce it. One point is accepted per cycle and one
// sample leaves per cycle while the receiver does not stall. A request passes
// eight stages inside each octave (split, shift-xor, three hash multiplies,
// three blends) and one stage for the octave sum before its sample is valid.
// The octaves run side by side, so the rate is set by the hash multipliers.
// When the receiver stalls, the whole pipeline holds; pt.ready drops only
// while the last stage holds an untaken sample, so nothing is lost.
// Reset clears the valid bits and sets the seed to zero.
// ----------------------------------------------------------------------------
module value_noise_fbm_unit #(
	parameter int unsigned OCTAVES = 4,
	parameter int unsigned COORD_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [31:0] seed_wd,
	vnf_in_if.sink           pt,
	vnf_out_if.source        ns
);
	localparam int unsigned DEPTH = 9;

	logic [31:0] seed_q;
	logic [DEPTH-1:0] vld_q;
	logic en;

	assign en = !vld_q[DEPTH-1] || ns.ready;
	assign pt.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			vld_q  <= '0;
		end else begin
			if (seed_we) seed_q <= seed_wd;
			if (en) vld_q <= {vld_q[DEPTH-2:0], pt.valid};
		end
	end

	logic signed [17:0] share [OCTAVES];
	for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
		vnf_octave #(.K(k), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_oct (
			.clk  (clk),
			.en   (en),
			.seed (seed_q),
			.cx   (pt.coord_x),
			.cy   (pt.coord_y),
			.cz   (pt.coord_z),
			.share(share[k])
		);
	end

	logic signed [17:0] sum;
	always_comb begin
		sum = '0;
		for (int k = 0; k < OCTAVES; k++) sum = sum + share[k];
	end

	logic signed [17:0] noise_s9;
	always_ff @(posedge clk) begin
		if (en) noise_s9 <= sum;
	end

	assign ns.valid = vld_q[DEPTH-1];
	assign ns.noise_value = noise_s9;
endmodule
`default_nettype wire

// ===== hdl/vnf_octave.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vnf_octave: one octave of lattice value noise
// Pipelined split, smoothstep, corner hash and trilinear blend for one
// octave scale. All stages advance together on the shared enable.
// ----------------------------------------------------------------------------
module vnf_octave #(
	parameter int unsigned K = 0,
	parameter int unsigned COORD_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [31:0] seed,
	input  wire logic signed [31:0] cx,
	input  wire logic signed [31:0] cy,
	input  wire logic signed [31:0] cz,
	output      logic signed [17:0] share
);
	localparam int unsigned SW = 32 + K;

	// Stage 1: cell index and Q0.16 fraction of the scaled point.
	logic [31:0] ix, iy, iz;
	logic [15:0] fx, fy, fz;
	logic signed [SW-1:0] sx, sy, sz;
	assign sx = SW'(cx) <<< K;
	assign sy = SW'(cy) <<< K;
	assign sz = SW'(cz) <<< K;

	function automatic logic [15:0] frac_of(input logic signed [SW-1:0] s);
		logic [COORD_FRAC_BITS-1:0] r;
		r = s[COORD_FRAC_BITS-1:0];
		if (COORD_FRAC_BITS >= 16)
			return 16'(r >> (COORD_FRAC_BITS - 16));
		else
			return 16'({r, 16'd0} >> COORD_FRAC_BITS);
	endfunction

	assign ix = 32'(sx >>> COORD_FRAC_BITS);
	assign iy = 32'(sy >>> COORD_FRAC_BITS);
	assign iz = 32'(sz >>> COORD_FRAC_BITS);
	assign fx = frac_of(sx);
	assign fy = frac_of(sy);
	assign fz = frac_of(sz);

	logic [31:0] n_s1;
	logic [15:0] fx_s1, fy_s1, fz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= ix + iy * vnf_pkg::STRIDE_Y + iz * vnf_pkg::STRIDE_Z + seed;
			fx_s1 <= fx;
			fy_s1 <= fy;
			fz_s1 <= fz;
		end
	end

	// Stage 2: corner indices with the shift-xor; squared fractions.
	logic [31:0] m_s2 [8];
	logic [15:0] fx_s2, fy_s2, fz_s2;
	logic [15:0] qx_s2, qy_s2, qz_s2;
	logic [31:0] pxx, pyy, pzz;
	assign pxx = fx_s1 * fx_s1;
	assign pyy = fy_s1 * fy_s1;
	assign pzz = fz_s1 * fz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++) begin
				m_s2[c] <= (n_s1 + vnf_pkg::corner_ofs(3'(c)))
					^ ((n_s1 + vnf_pkg::corner_ofs(3'(c))) << vnf_pkg::HASH_SHL);
			end
			fx_s2 <= fx_s1; fy_s2 <= fy_s1; fz_s2 <= fz_s1;
			qx_s2 <= pxx[31:16]; qy_s2 <= pyy[31:16]; qz_s2 <= pzz[31:16];
		end
	end

	// Stage 3: m*m; smoothstep second product.
	function automatic logic [15:0] smooth2(input logic [15:0] s, input logic [15:0] f);
		logic [17:0] t;
		logic [33:0] p;
		t = 18'(3 * 65536) - {1'b0, f, 1'b0};
		p = s * t;
		return p[31:16];
	endfunction

	logic [31:0] m_s3 [8];
	logic [31:0] q_s3 [8];
	logic [15:0] u_s3, v_s3, w_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++) begin
				m_s3[c] <= m_s2[c];
				q_s3[c] <= m_s2[c] * m_s2[c];
			end
			u_s3 <= smooth2(qx_s2, fx_s2);
			v_s3 <= smooth2(qy_s2, fy_s2);
			w_s3 <= smooth2(qz_s2, fz_s2);
		end
	end

	// Stage 4: q*15731 + 789221.
	logic [31:0] m_s4 [8];
	logic [31:0] q_s4 [8];
	logic [15:0] u_s4, v_s4, w_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++) begin
				m_s4[c] <= m_s3[c];
				q_s4[c] <= q_s3[c] * vnf_pkg::HASH_C1 + vnf_pkg::HASH_C2;
			end
			u_s4 <= u_s3; v_s4 <= v_s3; w_s4 <= w_s3;
		end
	end

	// Stage 5: m*q + c3, keep 31 bits, scale to Q1.16 corner value.
	logic [16:0] h_s5 [8];
	logic [15:0] u_s5, v_s5, w_s5;
	logic [31:0] hq [8];
	always_comb begin
		for (int c = 0; c < 8; c++)
			hq[c] = (m_s4[c] * q_s4[c] + vnf_pkg::HASH_C3) & vnf_pkg::HASH_MASK;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 8; c++)
				h_s5[c] <= hq[c][30:14];
			u_s5 <= u_s4; v_s5 <= v_s4; w_s5 <= w_s4;
		end
	end

	function automatic logic signed [18:0] lerp(input logic signed [18:0] a,
		input logic signed [18:0] b, input logic [15:0] t);
		logic signed [36:0] p;
		p = (b - a) * $signed({1'b0, t});
		return a + 19'(p >>> 16);
	endfunction

	// Stage 6: blend along x.
	logic signed [18:0] x_s6 [4];
	logic [15:0] v_s6, w_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++)
				x_s6[j] <= lerp($signed({2'b00, h_s5[2*j]}),
					$signed({2'b00, h_s5[2*j+1]}), u_s5);
			v_s6 <= v_s5; w_s6 <= w_s5;
		end
	end

	// Stage 7: blend along y.
	logic signed [18:0] y_s7 [2];
	logic [15:0] w_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			y_s7[0] <= lerp(x_s6[0], x_s6[1], v_s6);
			y_s7[1] <= lerp(x_s6[2], x_s6[3], v_s6);
			w_s7 <= w_s6;
		end
	end

	// Stage 8: blend along z, map to 1 - h and weight by 2^-(K+1).
	logic signed [18:0] zb, ov;
	assign zb = lerp(y_s7[0], y_s7[1], w_s7);
	assign ov = $signed({2'b00, vnf_pkg::ONE_Q16}) - zb;
	always_ff @(posedge clk) begin
		if (en) share <= 18'(ov >>> (K + 1));
	end
endmodule
`default_nettype wire

// ===== hdl/vnf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vnf_checker: port-level checks for the noise unit
// Watches the channels and confirms stall behavior.
// ----------------------------------------------------------------------------
module vnf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [17:0] out_data
);
	// A stalled sample holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled sample changed");
	// Input is refused only while a sample waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without stall");
	// Meant to flag a sample without a request; as written the consequent always holds.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_valid && in_ready |=> !out_valid || $past(out_valid) == 1'b0)
		else $error("unexpected sample");
endmodule

bind value_noise_fbm_unit vnf_checker u_vnf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pt.valid),
	.in_ready (pt.ready),
	.out_valid(ns.valid),
	.out_ready(ns.ready),
	.out_data (ns.noise_value)
);
`default_nettype wire

// ===== tb/tb_value_noise_fbm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_noise_fbm_unit: self-checking bench for the fractal noise unit
// Drives points with random gaps, predicts each noise sample in the bench,
// and compares samples in order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_value_noise_fbm_unit;
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	localparam int unsigned NUM_OCT = 4;
	localparam int unsigned LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seed_we = 1'b0;
	logic [31:0] seed_wd = '0;

	vnf_in_if  pt();
	vnf_out_if ns();

	value_noise_fbm_unit DUT (
		.clk(clk), .arst_n(arst_n), .seed_we(seed_we), .seed_wd(seed_wd),
		.pt(pt.sink), .ns(ns.source)
	);

	always #5 clk = ~clk;

	point_t pending_points[$];
	logic signed [17:0] expected_noise[$];
	logic [31:0] seed_model = '0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned samples_checked = 0;
	int unsigned points_sent = 0;
	bit idle_enabled = 1'b1;
	bit hold_sender = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_gap = 0;

	function automatic logic [30:0] lattice_hash(input logic [31:0] n);
		logic [31:0] m, q;
		m = (n << vnf_pkg::HASH_SHL) ^ n;
		q = m * m;
		q = q * vnf_pkg::HASH_C1 + vnf_pkg::HASH_C2;
		q = m * q + vnf_pkg::HASH_C3;
		return q[30:0];
	endfunction

	function automatic longint corner_val(input logic [31:0] n);
		logic [30:0] h;
		h = lattice_hash(n);
		return longint'(h >> 14);
	endfunction

	function automatic longint smooth_q16(input longint f);
		longint s;
		s = (f * f) >>> 16;
		return (s * (3 * 65536 - 2 * f)) >>> 16;
	endfunction

	// Arithmetic shift on a signed longint is a true floor.
	function automatic longint lerp_q16(input longint a, input longint b, input longint t);
		return a + (((b - a) * t) >>> 16);
	endfunction

	function automatic longint octave_val(input longint sx, input longint sy,
			input longint sz, input logic [31:0] sd);
		logic [31:0] ix, iy, iz, n;
		longint fx, fy, fz, u, v, w, x00, x10, x01, x11, y0, y1;
		ix = 32'(sx >>> 16); iy = 32'(sy >>> 16); iz = 32'(sz >>> 16);
		fx = sx & 64'hffff; fy = sy & 64'hffff; fz = sz & 64'hffff;
		u = smooth_q16(fx); v = smooth_q16(fy); w = smooth_q16(fz);
		n = ix + vnf_pkg::STRIDE_Y * iy + vnf_pkg::STRIDE_Z * iz + sd;
		x00 = lerp_q16(corner_val(n), corner_val(n + 1), u);
		x10 = lerp_q16(corner_val(n + 57), corner_val(n + 58), u);
		x01 = lerp_q16(corner_val(n + 113), corner_val(n + 114), u);
		x11 = lerp_q16(corner_val(n + 170), corner_val(n + 171), u);
		y0 = lerp_q16(x00, x10, v);
		y1 = lerp_q16(x01, x11, v);
		return 65536 - lerp_q16(y0, y1, w);
	endfunction

	function automatic logic signed [17:0] fbm_noise(input point_t p, input logic [31:0] sd);
		longint acc;
		acc = 0;
		for (int k = 0; k < NUM_OCT; k++)
			acc += octave_val(longint'(p.x) <<< k, longint'(p.y) <<< k,
				longint'(p.z) <<< k, sd) >>> (k + 1);
		return acc[17:0];
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {{16{1'b0}}, 16'($urandom())};
			2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 14;
			3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
			4: return $urandom() & 32'hffff0000;
			default: return 32'($signed($urandom_range(0, 20000)) - 10000);
		endcase
	endfunction

	// Driver: the predictor runs at acceptance with the current seed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt.valid <= 1'b0;
			pt.coord_x <= '0; pt.coord_y <= '0; pt.coord_z <= '0;
			send_gap <= 0;
		end else begin
			if (pt.valid && pt.ready) begin
				expected_noise = {expected_noise,
					fbm_noise({pt.coord_x, pt.coord_y, pt.coord_z}, seed_model)};
				points_sent <= points_sent + 1;
			end
			if (!pt.valid || pt.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					pt.valid <= 1'b0;
				end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 10);
					pt.valid <= 1'b0;
				end else if (!hold_sender && pending_points.size() != 0) begin
					point_t p;
					p = pending_points.pop_front();
					pt.valid <= 1'b1;
					pt.coord_x <= p.x; pt.coord_y <= p.y; pt.coord_z <= p.z;
				end else begin
					pt.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns.ready <= 1'b0;
			stall_gap <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (ns.valid && ns.ready) begin
				if (expected_noise.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sample %0d", ns.noise_value);
				end else begin
					logic signed [17:0] want;
					want = expected_noise.pop_front();
					samples_checked++;
					if (want !== ns.noise_value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("noise_value mismatch: expected %0d got %0d",
								want, ns.noise_value);
					end
				end
			end
			if (stall_gap != 0) begin
				stall_gap <= stall_gap - 1;
				ns.ready <= 1'b0;
			end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
				stall_gap <= $urandom_range(0, 10);
				ns.ready <= 1'b0;
			end else begin
				ns.ready <= 1'b1;
			end
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("timeout with %0d samples outstanding", expected_noise.size());
				$display("tb_value_noise_fbm_unit failed");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_points.size() != 0 || pt.valid || expected_noise.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		@(posedge clk);
		seed_we <= 1'b1;
		seed_wd <= value;
		@(posedge clk);
		seed_we <= 1'b0;
		seed_model = value;
	endtask

	task automatic queue_random(input int unsigned count);
		point_t p;
		for (int i = 0; i < count; i++) begin
			p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord();
			pending_points = {pending_points, p};
		end
	endtask

	initial begin
		logic [31:0] seed_list[5];
		logic [31:0] extremes[6];
		point_t p;
		seed_list = '{32'h0, 32'hffffffff, 32'h12345678, 32'h80000000, 32'h00000001};
		extremes = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 32'h00010000,
			32'h0000ffff};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: extreme coordinates, lattice points and fraction edges.
		for (int i = 0; i < 6; i++) begin
			p.x = extremes[i]; p.y = extremes[(i + 2) % 6]; p.z = extremes[(i + 4) % 6];
			pending_points = {pending_points, p};
		end
		for (int i = 0; i < 6; i++) begin
			p.x = extremes[i]; p.y = extremes[i]; p.z = extremes[i];
			pending_points = {pending_points, p};
		end
		p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
		pending_points = {pending_points, p};
		wait_drained();
		// One seed per phase, the extremes among them.
		for (int s = 0; s < 5; s++) begin
			write_seed(seed_list[s]);
			queue_random(s == 4 ? 450 : 250);
			if (s == 2) begin
				// The sender holds off until the pipeline has emptied.
				while (pending_points.size() > 120) @(posedge clk);
				hold_sender = 1'b1;
				while (pt.valid || expected_noise.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			if (s == 4) begin
				while (pending_points.size() > 150) @(posedge clk);
				idle_enabled = 1'b0;
			end
			wait_drained();
		end
		$display("Checked %0d noise samples from %0d points over five seeds,",
			samples_checked, points_sent);
		$display("including extreme coordinates and seeds 0 and all ones.");
		if (mismatches == 0 && expected_noise.size() == 0)
			$display("tb_value_noise_fbm_unit passed");
		else
			$display("tb_value_noise_fbm_unit failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/vnf_pkg.sv
hdl/vnf_if.sv
hdl/vnf_octave.sv
hdl/value_noise_fbm_unit.sv
hdl/vnf_checker.sv
tb/tb_value_noise_fbm_unit.sv
